>>> hdl/avm_pkg.sv
// ----------------------------------------------------------------------------
// avm_pkg
// Types and constants shared by the averaging voltmeter display block.
// ----------------------------------------------------------------------------
`default_nettype none

package avm_pkg;

    localparam int SAMPLE_W = 10;
    localparam int FS_W     = 7;
    localparam int SEG_W    = 7;
    localparam int BCD_W    = 8;
    localparam int DIGIT_W  = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [FS_W-1:0] FS_RESET = 7'd33;
    localparam logic [FS_W-1:0] FS_MAX   = 7'd99;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic REG_FULL_SCALE = 1'b0;

    localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
    };

    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic             high_digit_on;
        logic             low_digit_on;
        logic [BCD_W-1:0] reading_bcd;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scale_stat;

endpackage

`default_nettype wire

>>> hdl/avm_scale.sv
// ----------------------------------------------------------------------------
// avm_scale
// Four-stage pipeline that turns a completed group sum into the BCD reading.
// ----------------------------------------------------------------------------
`default_nettype none

module avm_scale
    import avm_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 8,
    parameter int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_READING)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_sum,
    input  wire logic [FS_W-1:0]  i_full_scale,
    output logic      [BCD_W-1:0] o_reading,
    output t_scale_stat           o_stat
);

    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int PROD2_W = SAMPLE_W + FS_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SUM_W) / SAMPLES_PER_READING);
    localparam logic [SUM_W-1:0]   N_C   = SUM_W'(SAMPLES_PER_READING);
    localparam logic [PROD2_W-1:0] ROUND_C = PROD2_W'(511);
    localparam logic [SAMPLE_W:0]  DIV_C   = 11'd1023;
    localparam int TENS_W = FS_W + 8;
    localparam logic [TENS_W-1:0]  TENS_MUL = TENS_W'(205);
    localparam logic [FS_W-1:0]    TEN_C    = 7'd10;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic [PROD_W-1:0]   r_prod1;
    logic [SUM_W-1:0]    r_sum1;
    logic [SAMPLE_W-1:0] r_avg;
    logic [PROD2_W-1:0]  r_prod2;
    logic [BCD_W-1:0]    r_reading;

    logic [SAMPLE_W-1:0] w_q0;
    logic [SUM_W-1:0]    w_qn;
    logic [SUM_W-1:0]    w_rem;
    logic [SAMPLE_W-1:0] n_avg;
    logic [FS_W-1:0]     w_q2;
    logic [SAMPLE_W:0]   w_r2;
    logic [FS_W-1:0]     w_t;
    logic [FS_W-1:0]     w_ts;
    logic [TENS_W-1:0]   w_tens_p;
    logic [DIGIT_W-1:0]  w_tens;
    logic [FS_W-1:0]     w_units_f;
    logic [BCD_W-1:0]    n_reading;

    always_comb begin
        w_q0  = r_prod1[SUM_W +: SAMPLE_W];
        w_qn  = SUM_W'(w_q0) * N_C;
        w_rem = r_sum1 - w_qn;
        n_avg = (w_rem >= N_C) ? w_q0 + 10'd1 : w_q0;
    end

    always_comb begin
        w_q2      = r_prod2[PROD2_W-1:SAMPLE_W];
        w_r2      = {1'b0, r_prod2[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(w_q2);
        w_t       = (w_r2 >= DIV_C) ? w_q2 + 7'd1 : w_q2;
        w_ts      = (w_t > FS_MAX) ? FS_MAX : w_t;
        w_tens_p  = TENS_W'(w_ts) * TENS_MUL;
        w_tens    = w_tens_p[TENS_W-1 -: DIGIT_W];
        w_units_f = w_ts - FS_W'(w_tens) * TEN_C;
        n_reading = {w_tens, w_units_f[DIGIT_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_reading <= '0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_v3) begin
                r_reading <= n_reading;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod1 <= PROD_W'(i_sum) * PROD_W'(RECIP);
        r_sum1  <= i_sum;
        r_avg   <= n_avg;
        r_prod2 <= PROD2_W'(r_avg) * PROD2_W'(i_full_scale) + ROUND_C;
    end

    assign o_reading   = r_reading;
    assign o_stat.busy = r_v1 | r_v2 | r_v3;
    assign o_stat.done = r_v4;

endmodule

`default_nettype wire

>>> hdl/adc_average_voltmeter_display.sv
// ----------------------------------------------------------------------------
// adc_average_voltmeter_display
// Averaging voltmeter feeding a two-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// A refresh request's result is registered in the output register when served.
// Throughput: one request per cycle; a refresh request waits in the input
// register while the result side is stalled or while the four-stage scaling
// pipeline writes the new reading after the sample completing a group.
// Reset (synchronous, active low) clears the sum, count, reading and digit
// select, and sets the full scale register to 33.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_average_voltmeter_display
    import avm_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_READING);
    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

    logic             r_in_vld;
    t_in_item         r_in;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_show_low;
    logic             r_out_vld;
    t_out_item        r_out;
    logic [FS_W-1:0]  r_fs;

    logic               w_is_tick;
    logic               w_out_free;
    logic               w_tick_go;
    logic               w_samp_go;
    logic               w_last;
    logic               w_start;
    logic [SUM_W-1:0]   w_sum_next;
    logic [DIGIT_W-1:0] w_digit;
    logic [BCD_W-1:0]   w_reading;
    logic               w_cfg_wr;
    logic [FS_W-1:0]    w_wdata;
    t_scale_stat        w_stat;

    assign w_is_tick  = (r_in.opcode == OP_TICK);
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_tick_go  = r_in_vld && w_is_tick && !w_stat.busy && w_out_free;
    assign w_samp_go  = r_in_vld && (r_in.opcode == OP_SAMPLE);
    assign w_last     = (r_cnt == CNT_LAST);
    assign w_start    = w_samp_go && w_last;
    assign w_sum_next = r_sum + SUM_W'(r_in.sample);
    assign w_digit    = r_show_low ? w_reading[DIGIT_W-1:0] : w_reading[BCD_W-1:DIGIT_W];
    assign o_in_ready = !r_in_vld || w_tick_go || w_samp_go;

    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FULL_SCALE);
    assign w_wdata  = pwdata[FS_W-1:0];
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_FULL_SCALE) ? APB_DW'(r_fs) : '0;

    avm_scale #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING),
        .SUM_W               (SUM_W)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_sum        (w_sum_next),
        .i_full_scale (r_fs),
        .o_reading    (w_reading),
        .o_stat       (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_sum      <= '0;
            r_cnt      <= '0;
            r_show_low <= 1'b0;
            r_out_vld  <= 1'b0;
            r_fs       <= FS_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_samp_go) begin
                if (w_last) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= w_sum_next;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (w_tick_go) begin
                r_show_low <= !r_show_low;
                r_out_vld  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_fs <= (w_wdata > FS_MAX) ? FS_MAX : w_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_tick_go) begin
            r_out.segments      <= SEG_TABLE[w_digit];
            r_out.high_digit_on <= !r_show_low;
            r_out.low_digit_on  <= r_show_low;
            r_out.reading_bcd   <= w_reading;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_tick_waits_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_go |-> !w_stat.busy)
        else $error("refresh request served while the reading was being updated");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_stat.busy)
        else $error("scaling pipeline did not take the completed group");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("sample count ran past the group size");

    a_reading_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (w_reading[3:0] <= 4'd9 && w_reading[7:4] <= 4'd9))
        else $error("reading is not a valid two-digit BCD value");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the averaging voltmeter display block.
// Sample and refresh requests are sent with random gaps, and the result side
// stalls at random. A scoreboard class keeps its own copy of the running sum,
// the reading and the digit select, and it predicts each displayed digit. The
// full scale register is rewritten over the APB port between phases. A short
// directed part covers empty, full scale and saturated readings. A long random
// part follows with sample levels that move about the whole converter range.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import avm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLES_PER_READING = 8;
    localparam int NUM_RANDOM_REQUESTS = 1250;
    localparam int SETTLE_CYCLES       = 8;
    localparam int WATCHDOG_LIMIT      = 2000;
    localparam int MAX_REPORTS         = 100;

    localparam logic [APB_AW-1:0] ADDR_FULL_SCALE = APB_AW'(4 * REG_FULL_SCALE);
    localparam logic [APB_AW-1:0] ADDR_UNUSED     = APB_AW'(4);

    class display_predictor #(int GROUP = 8);
        localparam int SUM_W = SAMPLE_W + $clog2(GROUP);

        bit [FS_W-1:0]    full_scale;
        bit [SUM_W-1:0]   sample_sum;
        int unsigned      sample_count;
        bit [BCD_W-1:0]   reading;
        bit               show_units;
        bit [SEG_W-1:0]   pattern [16];
        t_out_item        pending_digits [$];
        int               errors;

        function new();
            full_scale   = FS_RESET;
            sample_sum   = '0;
            sample_count = 0;
            reading      = '0;
            show_units   = 1'b0;
            errors       = 0;
            pattern = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
                        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71};
        endfunction

        function void write_register(int unsigned index, logic [APB_DW-1:0] value);
            if (index == REG_FULL_SCALE) begin
                full_scale = (value[FS_W-1:0] > FS_MAX) ? FS_MAX : value[FS_W-1:0];
            end
        endfunction

        function bit [BCD_W-1:0] scale_to_bcd(int unsigned average);
            int unsigned tenths;
            tenths = (average * full_scale + 511) / 1023;
            if (tenths > 99) begin
                tenths = 99;
            end
            return {4'(tenths / 10), 4'(tenths % 10)};
        endfunction

        function void take_request(t_in_item item);
            t_out_item digit;
            bit [DIGIT_W-1:0] value;
            if (item.opcode == OP_SAMPLE) begin
                sample_sum   += SUM_W'(item.sample);
                sample_count += 1;
                if (sample_count >= GROUP) begin
                    reading      = scale_to_bcd(sample_sum / GROUP);
                    sample_sum   = '0;
                    sample_count = 0;
                end
            end else begin
                value = show_units ? reading[3:0] : reading[7:4];
                digit.segments      = pattern[value];
                digit.high_digit_on = !show_units;
                digit.low_digit_on  = show_units;
                digit.reading_bcd   = reading;
                pending_digits.push_back(digit);
                show_units = !show_units;
            end
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("ERROR at %0t ns: %s", $time, what);
            end
        endtask

        task check_digit(t_out_item got);
            t_out_item want;
            if (pending_digits.size() == 0) begin
                report_mismatch("display result arrived with no refresh request pending");
            end else begin
                want = pending_digits.pop_front();
                if (got.segments !== want.segments) begin
                    report_mismatch($sformatf("segments: got %02h, expected %02h",
                                              got.segments, want.segments));
                end
                if (got.high_digit_on !== want.high_digit_on) begin
                    report_mismatch($sformatf("high_digit_on: got %b, expected %b",
                                              got.high_digit_on, want.high_digit_on));
                end
                if (got.low_digit_on !== want.low_digit_on) begin
                    report_mismatch($sformatf("low_digit_on: got %b, expected %b",
                                              got.low_digit_on, want.low_digit_on));
                end
                if (got.reading_bcd !== want.reading_bcd) begin
                    report_mismatch($sformatf("reading_bcd: got %02h, expected %02h",
                                              got.reading_bcd, want.reading_bcd));
                end
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data    = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    t_out_item         o_out_data;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [APB_AW-1:0] paddr        = '0;
    logic [APB_DW-1:0] pwdata       = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    display_predictor #(SAMPLES_PER_READING) predictor;
    bit                no_idle_in   = 1'b0;
    bit                no_idle_out  = 1'b0;
    int                stall_cycles = 0;

    adc_average_voltmeter_display #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_request(input t_in_item item);
        int gap;
        gap = no_idle_in ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predictor.take_request(item);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        predictor.write_register(addr >> 2, data);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item sample_request(logic [SAMPLE_W-1:0] value);
        t_in_item item;
        item.opcode = OP_SAMPLE;
        item.sample = value;
        return item;
    endfunction

    function automatic t_in_item tick_request();
        t_in_item item;
        item.opcode = OP_TICK;
        item.sample = SAMPLE_W'($urandom);
        return item;
    endfunction

    function automatic t_in_item random_request(int level);
        int value;
        if ($urandom_range(0, 2) == 0) begin
            return tick_request();
        end
        case ($urandom_range(0, 7))
            0: value = 0;
            1: value = 1023;
            2: value = $urandom_range(0, 1023);
            default: value = level + $urandom_range(0, 64) - 32;
        endcase
        if (value < 0) begin
            value = 0;
        end else if (value > 1023) begin
            value = 1023;
        end
        return sample_request(SAMPLE_W'(value));
    endfunction

    function automatic logic [APB_DW-1:0] random_full_scale();
        logic [APB_DW-1:0] value;
        value = $urandom;
        case ($urandom_range(0, 4))
            0: value[FS_W-1:0] = 7'd0;
            1: value[FS_W-1:0] = FS_MAX;
            2: value[FS_W-1:0] = 7'($urandom_range(100, 127));
            default: value[FS_W-1:0] = 7'($urandom_range(0, 99));
        endcase
        return value;
    endfunction

    initial begin : result_ready
        int stall;
        forever begin
            stall = no_idle_out ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            predictor.check_digit(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int sent;
        int phase_len;
        int level;
        predictor = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the reading is zero and the tens digit comes first.
        repeat (2) send_request(tick_request());
        settle();

        // A full scale beyond range saturates, and a write to an unused address is ignored.
        write_reg(ADDR_FULL_SCALE, APB_DW'(127));
        write_reg(ADDR_UNUSED, APB_DW'(5));
        repeat (SAMPLES_PER_READING) send_request(sample_request(10'h3FF));
        repeat (2) send_request(tick_request());
        repeat (SAMPLES_PER_READING) send_request(sample_request(10'h000));
        send_request(tick_request());
        settle();

        sent = 0;
        while (sent < NUM_RANDOM_REQUESTS) begin
            write_reg(ADDR_FULL_SCALE, random_full_scale());
            if ($urandom_range(0, 3) == 0) begin
                write_reg(ADDR_UNUSED, APB_DW'($urandom));
            end
            no_idle_in  = ($urandom_range(0, 3) == 0);
            no_idle_out = ($urandom_range(0, 3) == 0);
            level     = $urandom_range(0, 1023);
            phase_len = $urandom_range(60, 140);
            repeat (phase_len) begin
                if ($urandom_range(0, 15) == 0) begin
                    level = $urandom_range(0, 1023);
                end
                send_request(random_request(level));
                sent++;
            end
            settle();
        end

        if (predictor.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
